// File: sv/wsm_pkg.sv
`default_nettype none
package wsm_pkg;

    // Drive modes.
    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_OMNI4    = 3'd1;
    localparam logic [2:0] MODE_MECANUM  = 3'd2;
    localparam logic [2:0] MODE_OMNI3    = 3'd3;
    localparam logic [2:0] MODE_DIFF     = 3'd4;
    localparam logic [2:0] MODE_DEBUG    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;
    localparam logic [1:0] CFG_MOTOR = 2'd3;

    localparam int IN_W   = 14;
    localparam int CMD_W  = 16;
    localparam int SPD_W  = 18;   // signed wheel speed before limiting
    localparam int MAG_W  = 17;   // magnitude of a wheel speed
    localparam int NUM_W  = 32;   // magnitude times limit
    localparam int QUO_W  = 16;
    localparam int DIV_STAGES = 4;

    localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
    localparam logic signed [17:0] CMD_LIMIT      = 18'sd32767;

    typedef logic signed [SPD_W-1:0] t_spd;

    typedef struct packed {
        logic en0;
        logic en1;
    } t_mix_ctl;

    typedef struct packed {
        logic [DIV_STAGES-1:0] en;
    } t_div_ctl;

endpackage
`default_nettype wire

// File: sv/wsm_mix.sv
`default_nettype none
module wsm_mix (
    input  wire logic                          i_clk,
    input  wire wsm_pkg::t_mix_ctl             i_ctl,
    input  wire logic [2:0]                    i_mode,
    input  wire logic [9:0]                    i_gain,
    input  wire logic signed [13:0]            i_x,
    input  wire logic signed [13:0]            i_y,
    input  wire logic signed [13:0]            i_w,
    output wsm_pkg::t_spd                      o_spd [4],
    output logic                               o_lim_en
);
    import wsm_pkg::*;

    // First stage: operands and the two products.
    logic signed [13:0] r_x, r_y, r_w;
    logic signed [24:0] r_pwg;
    logic signed [29:0] r_pcy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en0) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_w   <= i_w;
            r_pwg <= i_w * $signed({1'b0, i_gain});
            r_pcy <= i_y * SQRT3_HALF_Q15;
        end
    end

    // Second stage: mixing per mode.
    logic signed [33:0] n_xs, n_ys, n_ts, n_a, n_b, n_c;
    logic signed [SPD_W-1:0] n_t, n_xe, n_ye, n_we;
    logic signed [SPD_W-1:0] n_q3 [3];
    logic signed [16:0] n_tq;
    t_spd n_spd [4];
    logic n_lim;

    function automatic logic signed [SPD_W-1:0] div32k(input logic signed [33:0] v);
        logic signed [33:0] q;
        q = v >>> 15;
        if (v[33] && (v[14:0] != 15'd0)) begin
            q = q + 34'sd1;
        end
        return q[SPD_W-1:0];
    endfunction

    always_comb begin
        n_xe = {{(SPD_W-14){r_x[13]}}, r_x};
        n_ye = {{(SPD_W-14){r_y[13]}}, r_y};
        n_we = {{(SPD_W-14){r_w[13]}}, r_w};
        n_tq = r_pwg[24:8];
        if (r_pwg[24] && (r_pwg[7:0] != 8'd0)) begin
            n_tq = n_tq + 17'sd1;
        end
        n_t  = {n_tq[16], n_tq};
        n_xs = {{20{r_x[13]}}, r_x} <<< 14;
        n_ys = {{4{r_pcy[29]}}, r_pcy};
        n_ts = {{9{r_pwg[24]}}, r_pwg} <<< 7;
        n_a  = n_ys - n_xs + n_ts;
        n_b  = n_ts - n_xs - n_ys;
        n_c  = (n_xs <<< 1) + n_ts;
        n_q3[0] = div32k(n_a);
        n_q3[1] = div32k(n_b);
        n_q3[2] = div32k(n_c);
        for (int i = 0; i < 4; i++) begin
            n_spd[i] = '0;
        end
        n_lim = 1'b0;
        if (i_mode == MODE_PLAIN) begin
            n_spd[0] = n_ye + n_we;
            n_spd[1] = n_ye - n_we;
            n_spd[2] = n_ye - n_we;
            n_spd[3] = n_ye + n_we;
            n_lim    = 1'b1;
        end else if (i_mode == MODE_OMNI4 || i_mode == MODE_MECANUM) begin
            n_spd[0] = n_ye - n_xe + n_t;
            n_spd[1] = n_ye + n_xe - n_t;
            n_spd[2] = n_ye - n_xe - n_t;
            n_spd[3] = n_ye + n_xe + n_t;
            n_lim    = 1'b1;
        end else if (i_mode == MODE_OMNI3) begin
            n_spd[0] = n_q3[0];
            n_spd[1] = n_q3[1];
            n_spd[2] = n_q3[2];
        end else if (i_mode == MODE_DIFF) begin
            n_spd[0] = n_ye + n_we;
            n_spd[1] = n_ye - n_we;
            n_lim    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            o_spd    <= n_spd;
            o_lim_en <= n_lim;
        end
    end

endmodule
`default_nettype wire

// File: sv/wsm_div.sv
`default_nettype none
module wsm_div (
    input  wire logic                          i_clk,
    input  wire wsm_pkg::t_div_ctl             i_ctl,
    input  wire logic [wsm_pkg::NUM_W-1:0]     i_num,
    input  wire logic [wsm_pkg::MAG_W-1:0]     i_den,
    input  wire logic [wsm_pkg::MAG_W-1:0]     i_mag,
    input  wire logic                          i_neg,
    output logic [wsm_pkg::QUO_W-1:0]          o_quo,
    output logic [wsm_pkg::MAG_W-1:0]          o_mag,
    output logic                               o_neg
);
    import wsm_pkg::*;

    localparam int STEPS = QUO_W / DIV_STAGES;

    // Restoring division, four quotient bits per stage. The quotient is known
    // to fit in sixteen bits, so the top half of the numerator starts as the
    // partial remainder.
    logic [MAG_W-1:0] r_rem [DIV_STAGES];
    logic [QUO_W-1:0] r_low [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];
    logic [MAG_W-1:0] r_den [DIV_STAGES];
    logic [MAG_W-1:0] r_mag [DIV_STAGES];
    logic             r_neg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
        logic [MAG_W-1:0] n_rem, s_rem, s_den, s_mag;
        logic [QUO_W-1:0] n_low, n_quo, s_low, s_quo;
        logic             s_neg;
        logic [MAG_W:0]   n_t;

        if (j == 0) begin : g_src
            assign s_rem = {1'b0, i_num[NUM_W-1:QUO_W]};
            assign s_low = i_num[QUO_W-1:0];
            assign s_quo = '0;
            assign s_den = i_den;
            assign s_mag = i_mag;
            assign s_neg = i_neg;
        end else begin : g_src
            assign s_rem = r_rem[j-1];
            assign s_low = r_low[j-1];
            assign s_quo = r_quo[j-1];
            assign s_den = r_den[j-1];
            assign s_mag = r_mag[j-1];
            assign s_neg = r_neg[j-1];
        end

        always_comb begin
            n_rem = s_rem;
            n_low = s_low;
            n_quo = s_quo;
            n_t   = '0;
            for (int k = 0; k < STEPS; k++) begin
                n_t   = {n_rem, n_low[QUO_W-1]};
                n_low = {n_low[QUO_W-2:0], 1'b0};
                if (n_t >= {1'b0, s_den}) begin
                    n_rem = MAG_W'(n_t - {1'b0, s_den});
                    n_quo = {n_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = n_t[MAG_W-1:0];
                    n_quo = {n_quo[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en[j]) begin
                r_rem[j] <= n_rem;
                r_low[j] <= n_low;
                r_quo[j] <= n_quo;
                r_den[j] <= s_den;
                r_mag[j] <= s_mag;
                r_neg[j] <= s_neg;
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
    assign o_mag = r_mag[DIV_STAGES-1];
    assign o_neg = r_neg[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: sv/wheel_speed_mixer.sv
// Wheel speed mixer: turns one motion command (sideways x, forward y, yaw rate)
// into four motor speed commands and a mask of the motors that receive one.
// Input channel: i_valid, i_x_speed, i_y_speed, i_turn_rate, with o_stall back.
// Output channel: o_valid, o_wheel1_cmd..o_wheel4_cmd, o_send_mask, with
// i_stall back. A request moves on a channel at a rising edge where valid is
// high and stall is low.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data): index
// 0 drive mode, 1 speed limit, 2 yaw gain, 3 motor present mask. Write it only
// while no request is inside the block.
// The datapath is a nine-stage pipeline: operand and product registers, the
// mixing stage, the magnitude and maximum stage, the limit product stage, four
// stages of a restoring divider (four quotient bits each) and the output
// register. One request can be accepted in every cycle while the receiver
// does not stall, since every stage can then advance each clock.
// Reset clears all valid bits and loads the register defaults (debug mode,
// limit 0, gain 1.0, no motors). When the receiver stalls, each stage holds
// only if the stage after it is full, so empty slots fill up before o_stall
// rises; no request is dropped or repeated.
`default_nettype none
module wheel_speed_mixer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [14:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [13:0]   i_x_speed,
    input  wire logic signed [13:0]   i_y_speed,
    input  wire logic signed [13:0]   i_turn_rate,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [15:0]        o_wheel1_cmd,
    output logic signed [15:0]        o_wheel2_cmd,
    output logic signed [15:0]        o_wheel3_cmd,
    output logic signed [15:0]        o_wheel4_cmd,
    output logic [3:0]                o_send_mask
);
    import wsm_pkg::*;

    localparam int NSTG = 9;

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [14:0] r_limit;
    logic [9:0]  r_gain;
    logic [3:0]  r_motor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DEBUG;
            r_limit <= '0;
            r_gain  <= 10'd256;
            r_motor <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                CFG_GAIN:  r_gain  <= i_cfg_data[9:0];
                CFG_MOTOR: r_motor <= i_cfg_data[3:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Valid bits and per-stage load enables. A stage loads when it is empty
    // or when the stage after it loads in the same cycle.
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    // Stages 0 and 1: products and mixing.
    t_mix_ctl mix_ctl;
    t_spd     mix_spd [4];
    logic     mix_lim;

    assign mix_ctl.en0 = en[0];
    assign mix_ctl.en1 = en[1];

    wsm_mix u_mix (
        .i_clk    (i_clk),
        .i_ctl    (mix_ctl),
        .i_mode   (r_mode),
        .i_gain   (r_gain),
        .i_x      (i_x_speed),
        .i_y      (i_y_speed),
        .i_w      (i_turn_rate),
        .o_spd    (mix_spd),
        .o_lim_en (mix_lim)
    );

    // Stage 2: magnitudes, largest magnitude, and whether to scale.
    logic [MAG_W-1:0] n_mag [4];
    logic             n_neg [4];
    logic [MAG_W-1:0] n_m01, n_m23, n_mx;
    logic [MAG_W-1:0] r2_mag [4];
    logic             r2_neg [4];
    logic [MAG_W-1:0] r2_mx;
    logic             r2_scale;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_neg[i] = mix_spd[i][SPD_W-1];
            n_mag[i] = n_neg[i] ? MAG_W'(-mix_spd[i]) : MAG_W'(mix_spd[i]);
        end
        n_m01 = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        n_m23 = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
        n_mx  = (n_m01 > n_m23) ? n_m01 : n_m23;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_mag   <= n_mag;
            r2_neg   <= n_neg;
            r2_mx    <= n_mx;
            r2_scale <= mix_lim && (n_mx > {2'b00, r_limit});
        end
    end

    // Stage 3: magnitude times the limit, the dividend of the scaling.
    logic [NUM_W-1:0] r3_num [4];
    logic [MAG_W-1:0] r3_mag [4];
    logic             r3_neg [4];
    logic [MAG_W-1:0] r3_mx;
    logic             r3_scale;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 4; i++) begin
                r3_num[i] <= r2_mag[i] * r_limit;
            end
            r3_mag   <= r2_mag;
            r3_neg   <= r2_neg;
            r3_mx    <= r2_mx;
            r3_scale <= r2_scale;
        end
    end

    // Stages 4 to 7: one divider lane per wheel.
    t_div_ctl         div_ctl;
    logic [QUO_W-1:0] div_quo [4];
    logic [MAG_W-1:0] div_mag [4];
    logic             div_neg [4];
    logic             r_scale_p [DIV_STAGES];

    assign div_ctl.en = en[7:4];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        wsm_div u_div (
            .i_clk (i_clk),
            .i_ctl (div_ctl),
            .i_num (r3_num[i]),
            .i_den (r3_mx),
            .i_mag (r3_mag[i]),
            .i_neg (r3_neg[i]),
            .o_quo (div_quo[i]),
            .o_mag (div_mag[i]),
            .o_neg (div_neg[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_scale_p[0] <= r3_scale;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (en[4+k]) begin
                r_scale_p[k] <= r_scale_p[k-1];
            end
        end
    end

    // Stage 8: restore signs, apply the motor signs, saturate.
    function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [SPD_W-1:0] v);
        if (v > CMD_LIMIT) begin
            return CMD_W'(CMD_LIMIT);
        end else if (v < -CMD_LIMIT) begin
            return CMD_W'(-CMD_LIMIT);
        end
        return v[CMD_W-1:0];
    endfunction

    logic [MAG_W-1:0]        n_val [4];
    logic signed [SPD_W-1:0] n_s   [4];
    logic [3:0]              n_used;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_val[i] = r_scale_p[DIV_STAGES-1] ? {1'b0, div_quo[i]} : div_mag[i];
            n_s[i]   = div_neg[i] ? -$signed({1'b0, n_val[i]}) : $signed({1'b0, n_val[i]});
        end
        if (r_mode == MODE_OMNI3) begin
            n_used = 4'b0111;
        end else if (r_mode == MODE_DIFF) begin
            n_used = 4'b0011;
        end else begin
            n_used = 4'b1111;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            o_wheel1_cmd <= sat_cmd(-n_s[0]);
            o_wheel2_cmd <= sat_cmd(n_s[1]);
            o_wheel3_cmd <= sat_cmd(-n_s[2]);
            o_wheel4_cmd <= sat_cmd(-n_s[3]);
            o_send_mask  <= r_motor & n_used;
        end
    end

endmodule
`default_nettype wire

// File: sv/wsm_checker.sv
`default_nettype none
module wsm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [15:0] o_wheel1_cmd,
    input wire logic signed [15:0] o_wheel2_cmd,
    input wire logic signed [15:0] o_wheel3_cmd,
    input wire logic signed [15:0] o_wheel4_cmd,
    input wire logic [3:0]         o_send_mask
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result withdrawn under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_wheel1_cmd) && $stable(o_wheel2_cmd)
            && $stable(o_wheel3_cmd) && $stable(o_wheel4_cmd) && $stable(o_send_mask))
        else $error("stalled result changed");

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_wheel1_cmd != 16'sh8000 && o_wheel2_cmd != 16'sh8000
            && o_wheel3_cmd != 16'sh8000 && o_wheel4_cmd != 16'sh8000)
        else $error("command outside saturation range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

endmodule

bind wheel_speed_mixer wsm_checker u_wsm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_wheel1_cmd (o_wheel1_cmd),
    .o_wheel2_cmd (o_wheel2_cmd),
    .o_wheel3_cmd (o_wheel3_cmd),
    .o_wheel4_cmd (o_wheel4_cmd),
    .o_send_mask  (o_send_mask)
);
`default_nettype wire

// File: sim/tb_wheel_speed_mixer.sv
`default_nettype none
module tb_wheel_speed_mixer;
    import wsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One motion command as it enters the mixer.
    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic signed [13:0] w;
    } t_motion;

    // One set of motor commands as it leaves the mixer.
    typedef struct packed {
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [15:0] c3;
        logic signed [15:0] c4;
        logic [3:0]         mask;
    } t_wheels;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_MODE;
    logic [14:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [13:0] i_x_speed = '0;
    logic signed [13:0] i_y_speed = '0;
    logic signed [13:0] i_turn_rate = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_wheel1_cmd;
    logic signed [15:0] o_wheel2_cmd;
    logic signed [15:0] o_wheel3_cmd;
    logic signed [15:0] o_wheel4_cmd;
    logic [3:0]         o_send_mask;

    wheel_speed_mixer i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the configuration registers, kept in step with the writes.
    logic [2:0]  mode_r   = MODE_DEBUG;
    logic [14:0] limit_r  = '0;
    logic [9:0]  gain_r   = 10'd256;
    logic [3:0]  motors_r = '0;

    t_motion pending_cmds[$];
    t_wheels wheels_due[$];
    int      n_errors = 0;
    bit      long_hold = 1'b0;   // receiver forced to stall for a long stretch
    bit      finishing = 1'b0;
    bit      in_held = 1'b0;     // offered request was refused at the last rising edge

    function automatic longint clamp_cmd(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    // Inverse kinematics for one command under the current register settings.
    // SystemVerilog division truncates toward zero, as the hardware must.
    function automatic t_wheels mix_wheels(t_motion m);
        longint x, y, w, g, t, yt, mx, lim;
        longint s[4];
        logic [3:0] used;
        t_wheels r;
        x = m.x; y = m.y; w = m.w; g = gain_r; lim = limit_r;
        s = '{0, 0, 0, 0};
        used = 4'hF;
        mx = 0;
        case (mode_r)
            MODE_PLAIN, MODE_OMNI4, MODE_MECANUM: begin
                if (mode_r == MODE_PLAIN) begin
                    x = 0;
                    t = w;
                end else begin
                    t = (w * g) / 256;
                end
                s[0] = y - x + t;
                s[1] = y + x - t;
                s[2] = y - x - t;
                s[3] = y + x + t;
            end
            MODE_OMNI3: begin
                yt = 128 * g * w;
                s[0] = (-16384 * x + 28378 * y + yt) / 32768;
                s[1] = (-16384 * x - 28378 * y + yt) / 32768;
                s[2] = (32768 * x + yt) / 32768;
                used = 4'h7;
            end
            MODE_DIFF: begin
                s[0] = y + w;
                s[1] = y - w;
                used = 4'h3;
            end
            default: used = 4'hF;
        endcase
        // Proportional limiting applies to the four-wheel and differential modes.
        if (mode_r <= MODE_MECANUM || mode_r == MODE_DIFF) begin
            foreach (s[i]) if ((s[i] < 0 ? -s[i] : s[i]) > mx) mx = s[i] < 0 ? -s[i] : s[i];
            if (mx > lim) foreach (s[i]) s[i] = s[i] * lim / mx;
        end
        r.c1 = 16'(clamp_cmd(-s[0]));
        r.c2 = 16'(clamp_cmd(s[1]));
        r.c3 = 16'(clamp_cmd(-s[2]));
        r.c4 = 16'(clamp_cmd(-s[3]));
        r.mask = motors_r & used;
        return r;
    endfunction

    // Remembers whether the offered request was refused at the rising edge.
    always @(posedge i_clk) begin
        in_held <= i_valid && o_stall;
    end

    // Sender: offers queued commands with random gaps, changing on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && !in_held) begin
            if (pending_cmds.size() > 0 && ($urandom_range(0, 3) != 0)) begin
                i_valid     <= 1'b1;
                i_x_speed   <= pending_cmds[0].x;
                i_y_speed   <= pending_cmds[0].y;
                i_turn_rate <= pending_cmds[0].w;
                void'(pending_cmds.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: mostly short stalls, and one long one.
    always @(negedge i_clk) begin
        if (long_hold)
            i_stall <= 1'b1;
        else if (finishing)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 5) == 0) ||
                       ($urandom_range(0, 99) == 0 ? 1'b1 : 1'b0);
    end

    // Monitor: predicts at input acceptance, checks at output acceptance.
    always @(posedge i_clk) begin
        t_motion m;
        t_wheels got, want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                m = '{x: i_x_speed, y: i_y_speed, w: i_turn_rate};
                wheels_due.push_back(mix_wheels(m));
            end
            if (o_valid && !i_stall) begin
                got = '{o_wheel1_cmd, o_wheel2_cmd, o_wheel3_cmd, o_wheel4_cmd,
                        o_send_mask};
                if (wheels_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected output %p", got);
                end else begin
                    want = wheels_due.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: expected %p got %p", want, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  mode_r   = val[2:0];
            CFG_LIMIT: limit_r  = val;
            CFG_GAIN:  gain_r   = val[9:0];
            default:   motors_r = val[3:0];
        endcase
    endtask

    task automatic setup_mixer(logic [2:0] md, logic [14:0] lim, logic [9:0] g,
                               logic [3:0] mot);
        write_reg(CFG_MODE, 15'(md));
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_GAIN, 15'(g));
        write_reg(CFG_MOTOR, 15'(mot));
    endtask

    // Waits until every queued command has left the block, plus pipeline slack.
    task automatic drain;
        while (pending_cmds.size() > 0 || i_valid || wheels_due.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic signed [13:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 14'sh2000;
            1: return 14'sh1FFF;
            2: return 14'(int'($urandom_range(0, 40)) - 20);
            default: return 14'($urandom);
        endcase
    endfunction

    task automatic add_cmd(logic signed [13:0] x, logic signed [13:0] y,
                           logic signed [13:0] w);
        pending_cmds.push_back('{x: x, y: y, w: w});
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: debug mode, every command zero, no motors flagged.
        add_cmd(14'sh1FFF, 14'sh2000, 14'sd100);
        drain();

        // Directed part: each mode with extremes, two unknown modes, zero limit,
        // maximum gain, and the three-wheel path with no limit.
        for (int md = 0; md < 8; md++) begin
            setup_mixer(3'(md), (md == 1) ? 15'd0 : 15'h7FFF, (md == 2) ? 10'h3FF : 10'd256,
                        4'(md + 9));
            add_cmd(14'sh1FFF, 14'sh1FFF, 14'sh1FFF);
            add_cmd(14'sh2000, 14'sh2000, 14'sh2000);
            add_cmd(14'sh2000, 14'sh1FFF, 14'sh0000);
            drain();
        end

        // Random part: several configurations, including the extremes.
        for (int ph = 0; ph < 12; ph++) begin
            setup_mixer(3'($urandom_range(0, 7)),
                        ph == 0 ? 15'h7FFF : ph == 1 ? 15'd0 :
                        ($urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 3000))),
                        ph == 2 ? 10'h3FF : ph == 3 ? 10'd0 : 10'($urandom),
                        4'($urandom));
            for (int k = 0; k < 78; k++)
                add_cmd(rand_speed(), rand_speed(), rand_speed());
            if (ph == 5) begin
                // Hold the receiver off so the pipeline fills and stalls the sender.
                long_hold = 1'b1;
                repeat (60) @(posedge i_clk);
                long_hold = 1'b0;
            end
            drain();
        end

        finishing = 1'b1;
        drain();
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
